### src/hucm_pkg.sv
package hucm_pkg;

   // cordic iteration count and angle width (radians, 28 fraction bits)
   localparam int ITERS = 28;
   localparam int ZW    = 32;
   // quotient bits kept from the column angle divide (angle mod 2*pi)
   localparam int QBITS = 21;

   localparam logic [31:0]        INV_PI_Q32  = 32'd1367130551;
   localparam logic [29:0]        PI_Q28      = 30'd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

   // register indexes of the csr port
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic {
      CORDIC_ROTATE,
      CORDIC_VECTOR
   } cordic_mode_type;

   // atan(2^-i) in radians, 28 fraction bits
   localparam logic signed [ZW-1:0] ATAN_Q28 [0:ITERS-1] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32,
      32'sd16,        32'sd8,         32'sd4,        32'sd2
   };

endpackage

### src/hucm_div_stage.sv
module hucm_div_stage import hucm_pkg::*; #(
   parameter int CB  = 12,
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [CB-1:0]    divisor,
   input  logic             vld_i,
   input  logic [CB-1:0]    u_i,
   input  logic [CB-1:0]    v_i,
   input  logic [CB-1:0]    rem_i,
   input  logic [QBITS-1:0] quo_i,
   output logic             vld_o,
   output logic [CB-1:0]    u_o,
   output logic [CB-1:0]    v_o,
   output logic [CB-1:0]    rem_o,
   output logic [QBITS-1:0] quo_o
);

   logic             vld_ff;
   logic [CB-1:0]    u_ff, v_ff, rem_ff;
   logic [QBITS-1:0] quo_ff;
   logic             nbit;
   logic [CB:0]      trial;
   logic             take;
   logic [CB:0]      rem_in;

   // dividend is the column shifted up by 20, low bits are zero
   generate
      if (BIT >= 20) begin : g_ubit
         assign nbit = u_i[BIT-20];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
   endgenerate

   // one restoring divide step
   always_comb begin
      trial  = {rem_i, nbit};
      take   = trial >= {1'b0, divisor};
      rem_in = take ? trial - {1'b0, divisor} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_i;
         v_ff   <= v_i;
         rem_ff <= rem_in[CB-1:0];
         quo_ff <= {quo_i[QBITS-2:0], take};
      end
   end

   assign vld_o = vld_ff;
   assign u_o   = u_ff;
   assign v_o   = v_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

### src/hucm_cordic_stage.sv
module hucm_cordic_stage import hucm_pkg::*; #(
   parameter cordic_mode_type MODE = CORDIC_ROTATE,
   parameter int IDX = 0,
   parameter int DW  = 33,
   parameter int SW  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic signed [DW-1:0] x_i,
   input  logic signed [DW-1:0] y_i,
   input  logic signed [ZW-1:0] z_i,
   input  logic [SW-1:0]        side_i,
   output logic                 vld_o,
   output logic signed [DW-1:0] x_o,
   output logic signed [DW-1:0] y_o,
   output logic signed [ZW-1:0] z_o,
   output logic [SW-1:0]        side_o
);

   logic                 vld_ff;
   logic signed [DW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic [SW-1:0]        side_ff;
   logic signed [DW-1:0] dx, dy;
   logic                 turn;

   // turn: x -= y/2^i, y += x/2^i, z -= atan
   always_comb begin
      dx = y_i >>> IDX;
      dy = x_i >>> IDX;
      if (MODE == CORDIC_ROTATE) begin
         turn = z_i >= 0;
      end else begin
         turn = !(y_i > 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_i;
         if (turn) begin
            x_ff <= x_i - dx;
            y_ff <= y_i + dy;
            z_ff <= z_i - ATAN_Q28[IDX];
         end else begin
            x_ff <= x_i + dx;
            y_ff <= y_i - dy;
            z_ff <= z_i + ATAN_Q28[IDX];
         end
      end
   end

   assign vld_o  = vld_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign side_o = side_ff;

endmodule

### src/hemicylinder_undistort_coord_map_unit.sv
// channel  | direction | tdata fields, low bit up        | tuser/tlast
// req_     | in        | pixel_col, pixel_row             | none
// rsp_     | out       | source_x, source_y (signed)      | none
// csr_     | in        | index 0 image_width, 1 height    | write only
//
// one beat accepted per cycle while the pipeline is not stalled; the path is
// COORD_BITS+20 divide stages, four 28-step cordic chains (rotate, vector,
// vector, rotate), six arithmetic stages and the output register.
// reset is synchronous, clears all valid bits and loads 640 by 480.
// a stall freezes the whole pipeline once the output skid register fills;
// csr derived constants are registered from the csr registers, x0 in turn from r.
module hemicylinder_undistort_coord_map_unit import hucm_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 5
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // pixel_col, pixel_row
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // source_x, source_y
   output logic [((2*(COORD_BITS+FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   input  logic                                      csr_we,
   input  logic                                      csr_index,
   input  logic [COORD_BITS-1:0]                     csr_wdata
);

   localparam int CB    = COORD_BITS;
   localparam int DW    = COORD_BITS + 21;
   localparam int RW    = COORD_BITS + 15;
   localparam int MW    = RW + 3;
   localparam int OB    = COORD_BITS + FRAC_BITS + 2;
   localparam int NB    = COORD_BITS + 20;
   localparam int SH    = 16 - FRAC_BITS;
   localparam int EW    = DW + 2;
   localparam int RSP_W = ((2*OB+7)/8)*8;

   logic en;

   // csr registers and constants derived from them
   logic [CB-1:0]        width_ff, height_ff;
   logic [RW-1:0]        r_ff;
   logic signed [DW-1:0] x0_ff;
   logic [CB-1:0]        div_ff, cx_ff, cy_ff;
   logic [63:0]          r_prod, x0_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CB'(640);
         height_ff <= CB'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      r_prod  = 64'(width_ff) * 64'(INV_PI_Q32) + 64'd32768;
      x0_prod = 64'(r_ff) * 64'(GAIN_Q30);
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_prod[16 +: RW];
      x0_ff  <= $signed(DW'(x0_prod[30 +: RW]));
      div_ff <= (width_ff == '0) ? CB'(1) : width_ff;
      cx_ff  <= width_ff >> 1;
      cy_ff  <= height_ff >> 1;
   end

   // column angle divide: floor(u * 2^20 / width)
   logic          dv_vld [0:NB];
   logic [CB-1:0] dv_u [0:NB];
   logic [CB-1:0] dv_v [0:NB];
   logic [CB-1:0] dv_rem [0:NB];
   logic [QBITS-1:0] dv_quo [0:NB];

   assign req_tready = en;
   assign dv_vld[0] = req_tvalid;
   assign dv_u[0]   = req_tdata[CB-1:0];
   assign dv_v[0]   = req_tdata[2*CB-1:CB];
   assign dv_rem[0] = '0;
   assign dv_quo[0] = '0;

   genvar k;
   generate
      for (k = 0; k < NB; k++) begin : g_div
         hucm_div_stage #(.CB(CB), .BIT(NB-1-k)) u_div (
            .clock(clock), .reset(reset), .en(en), .divisor(div_ff),
            .vld_i(dv_vld[k]), .u_i(dv_u[k]), .v_i(dv_v[k]),
            .rem_i(dv_rem[k]), .quo_i(dv_quo[k]),
            .vld_o(dv_vld[k+1]), .u_o(dv_u[k+1]), .v_o(dv_v[k+1]),
            .rem_o(dv_rem[k+1]), .quo_o(dv_quo[k+1])
         );
      end
   endgenerate

   // fold the angle into the first quadrant and scale to radians
   logic          a_vld_ff, a_sgn_ff;
   logic [29:0]   a_rad_ff;
   logic [CB-1:0] a_v_ff;
   logic [19:0]   a_s, a_fold;
   logic          a_back;
   logic [49:0]   a_prod;

   always_comb begin
      a_s    = dv_quo[NB][19:0];
      a_back = a_s > 20'h80000;
      a_fold = a_back ? 20'h00000 - a_s : a_s;
      a_prod = 50'(a_fold) * 50'(PI_Q28);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= dv_vld[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rad_ff <= a_prod[20 +: 30];
         a_sgn_ff <= a_back ^ dv_quo[NB][20];
         a_v_ff   <= dv_v[NB];
      end
   end

   // first rotation: cos and sin of the column angle times r
   logic                 r1_vld [0:ITERS];
   logic signed [DW-1:0] r1_x [0:ITERS];
   logic signed [DW-1:0] r1_y [0:ITERS];
   logic signed [ZW-1:0] r1_z [0:ITERS];
   logic [CB:0]          r1_side [0:ITERS];

   assign r1_vld[0]  = a_vld_ff;
   assign r1_x[0]    = x0_ff;
   assign r1_y[0]    = '0;
   assign r1_z[0]    = $signed(ZW'(a_rad_ff));
   assign r1_side[0] = {a_sgn_ff, a_v_ff};

   generate
      for (k = 0; k < ITERS; k++) begin : g_rot1
         hucm_cordic_stage #(.MODE(CORDIC_ROTATE), .IDX(k), .DW(DW), .SW(CB+1)) u_st (
            .clock(clock), .reset(reset), .en(en), .vld_i(r1_vld[k]),
            .x_i(r1_x[k]), .y_i(r1_y[k]), .z_i(r1_z[k]), .side_i(r1_side[k]),
            .vld_o(r1_vld[k+1]), .x_o(r1_x[k+1]), .y_o(r1_y[k+1]),
            .z_o(r1_z[k+1]), .side_o(r1_side[k+1])
         );
      end
   endgenerate

   // build xp, zp, yp and fold into the right half plane
   logic                 b_vld_ff, b_flip_ff, b_ctr_ff;
   logic signed [DW-1:0] b_a_ff, b_b_ff, b_zp_ff;
   logic signed [DW-1:0] b_xp, b_yp, b_zp;
   logic                 b_flip;

   always_comb begin
      b_xp   = r1_side[ITERS][CB] ? r1_x[ITERS] : -r1_x[ITERS];
      b_zp   = (r1_y[ITERS] < 0) ? -r1_y[ITERS] : r1_y[ITERS];
      b_yp   = (DW'(r1_side[ITERS][CB-1:0]) - DW'(cy_ff)) << 16;
      b_flip = b_xp < 0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= r1_vld[ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_a_ff    <= b_flip ? -b_xp : b_xp;
         b_b_ff    <= b_flip ? -b_yp : b_yp;
         b_zp_ff   <= b_zp;
         b_flip_ff <= b_flip;
         b_ctr_ff  <= (b_xp == 0) && (b_yp == 0);
      end
   end

   // first vectoring: direction phi and magnitude of (xp, yp)
   logic                 v1_vld [0:ITERS];
   logic signed [DW-1:0] v1_x [0:ITERS];
   logic signed [DW-1:0] v1_y [0:ITERS];
   logic signed [ZW-1:0] v1_z [0:ITERS];
   logic [DW+1:0]        v1_side [0:ITERS];

   assign v1_vld[0]  = b_vld_ff;
   assign v1_x[0]    = b_a_ff;
   assign v1_y[0]    = b_b_ff;
   assign v1_z[0]    = '0;
   assign v1_side[0] = {b_ctr_ff, b_flip_ff, b_zp_ff};

   generate
      for (k = 0; k < ITERS; k++) begin : g_vec1
         hucm_cordic_stage #(.MODE(CORDIC_VECTOR), .IDX(k), .DW(DW), .SW(DW+2)) u_st (
            .clock(clock), .reset(reset), .en(en), .vld_i(v1_vld[k]),
            .x_i(v1_x[k]), .y_i(v1_y[k]), .z_i(v1_z[k]), .side_i(v1_side[k]),
            .vld_o(v1_vld[k+1]), .x_o(v1_x[k+1]), .y_o(v1_y[k+1]),
            .z_o(v1_z[k+1]), .side_o(v1_side[k+1])
         );
      end
   endgenerate

   // remove the cordic gain from rp
   logic                 c_vld_ff, c_flip_ff, c_ctr_ff;
   logic signed [DW-1:0] c_rp_ff, c_zp_ff;
   logic signed [ZW-1:0] c_phi_ff;
   logic signed [DW+31:0] c_prod;

   assign c_prod = v1_x[ITERS] * GAIN_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= v1_vld[ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_rp_ff   <= $signed(c_prod[30 +: DW]);
         c_zp_ff   <= $signed(v1_side[ITERS][DW-1:0]);
         c_flip_ff <= v1_side[ITERS][DW];
         c_ctr_ff  <= v1_side[ITERS][DW+1];
         c_phi_ff  <= v1_z[ITERS];
      end
   end

   // second vectoring: theta = atan(rp / zp)
   logic                 v2_vld [0:ITERS];
   logic signed [DW-1:0] v2_x [0:ITERS];
   logic signed [DW-1:0] v2_y [0:ITERS];
   logic signed [ZW-1:0] v2_z [0:ITERS];
   logic [ZW+2:0]        v2_side [0:ITERS];

   assign v2_vld[0]  = c_vld_ff;
   assign v2_x[0]    = c_zp_ff;
   assign v2_y[0]    = c_rp_ff;
   assign v2_z[0]    = '0;
   assign v2_side[0] = {c_ctr_ff, c_flip_ff, (c_zp_ff == 0), c_phi_ff};

   generate
      for (k = 0; k < ITERS; k++) begin : g_vec2
         hucm_cordic_stage #(.MODE(CORDIC_VECTOR), .IDX(k), .DW(DW), .SW(ZW+3)) u_st (
            .clock(clock), .reset(reset), .en(en), .vld_i(v2_vld[k]),
            .x_i(v2_x[k]), .y_i(v2_y[k]), .z_i(v2_z[k]), .side_i(v2_side[k]),
            .vld_o(v2_vld[k+1]), .x_o(v2_x[k+1]), .y_o(v2_y[k+1]),
            .z_o(v2_z[k+1]), .side_o(v2_side[k+1])
         );
      end
   endgenerate

   // m = r * theta, with a right angle where zp is zero
   logic                 d_vld_ff, d_flip_ff, d_ctr_ff;
   logic signed [MW-1:0] d_m_ff;
   logic signed [ZW-1:0] d_phi_ff, d_theta;
   logic signed [RW+ZW:0] d_prod;

   always_comb begin
      d_theta = v2_side[ITERS][ZW] ? HALF_PI_Q28 : v2_z[ITERS];
      d_prod  = $signed({1'b0, r_ff}) * d_theta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= v2_vld[ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_m_ff    <= $signed(d_prod[28 +: MW]);
         d_phi_ff  <= v2_side[ITERS][ZW-1:0];
         d_flip_ff <= v2_side[ITERS][ZW+1];
         d_ctr_ff  <= v2_side[ITERS][ZW+2];
      end
   end

   // pre-scale the radius by the cordic gain
   logic                 e_vld_ff, e_flip_ff, e_ctr_ff;
   logic signed [DW-1:0] e_ox_ff;
   logic signed [ZW-1:0] e_phi_ff;
   logic signed [MW+31:0] e_prod;

   assign e_prod = d_m_ff * GAIN_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ox_ff   <= $signed(e_prod[30 +: DW]);
         e_phi_ff  <= d_phi_ff;
         e_flip_ff <= d_flip_ff;
         e_ctr_ff  <= d_ctr_ff;
      end
   end

   // second rotation: turn the radius back onto direction phi
   logic                 r3_vld [0:ITERS];
   logic signed [DW-1:0] r3_x [0:ITERS];
   logic signed [DW-1:0] r3_y [0:ITERS];
   logic signed [ZW-1:0] r3_z [0:ITERS];
   logic [1:0]           r3_side [0:ITERS];

   assign r3_vld[0]  = e_vld_ff;
   assign r3_x[0]    = e_ox_ff;
   assign r3_y[0]    = '0;
   assign r3_z[0]    = e_phi_ff;
   assign r3_side[0] = {e_ctr_ff, e_flip_ff};

   generate
      for (k = 0; k < ITERS; k++) begin : g_rot3
         hucm_cordic_stage #(.MODE(CORDIC_ROTATE), .IDX(k), .DW(DW), .SW(2)) u_st (
            .clock(clock), .reset(reset), .en(en), .vld_i(r3_vld[k]),
            .x_i(r3_x[k]), .y_i(r3_y[k]), .z_i(r3_z[k]), .side_i(r3_side[k]),
            .vld_o(r3_vld[k+1]), .x_o(r3_x[k+1]), .y_o(r3_y[k+1]),
            .z_o(r3_z[k+1]), .side_o(r3_side[k+1])
         );
      end
   endgenerate

   // round to the output fraction, add the center, saturate
   function automatic logic [OB-1:0] finish(input logic signed [DW-1:0] off,
                                            input logic [CB-1:0] center);
      logic signed [EW-1:0] val;
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] lo;
      hi  = (EW'(1) <<< (OB-1)) - EW'(1);
      lo  = -hi - EW'(1);
      val = (EW'(off) + (EW'(1) <<< (SH-1))) >>> SH;
      val = val + (EW'(center) <<< FRAC_BITS);
      if (val > hi) begin
         val = hi;
      end
      if (val < lo) begin
         val = lo;
      end
      return val[OB-1:0];
   endfunction

   logic                 f_vld_ff;
   logic [OB-1:0]        f_x_ff, f_y_ff;
   logic signed [DW-1:0] f_ox, f_oy;

   always_comb begin
      f_ox = r3_side[ITERS][0] ? -r3_x[ITERS] : r3_x[ITERS];
      f_oy = r3_side[ITERS][0] ? -r3_y[ITERS] : r3_y[ITERS];
      if (r3_side[ITERS][1]) begin
         f_ox = '0;
         f_oy = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= r3_vld[ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_x_ff <= finish(f_ox, cx_ff);
         f_y_ff <= finish(f_oy, cy_ff);
      end
   end

   // output register with a skid register behind it
   logic            out_vld_ff, skid_vld_ff;
   logic [2*OB-1:0] out_data_ff, skid_data_ff;

   assign en = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_vld_ff && !rsp_tready) begin
         if (f_vld_ff && en) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (skid_vld_ff) begin
         out_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_vld_ff && !rsp_tready) begin
         if (en) begin
            skid_data_ff <= {f_y_ff, f_x_ff};
         end
      end else if (skid_vld_ff) begin
         out_data_ff <= skid_data_ff;
      end else begin
         out_data_ff <= {f_y_ff, f_x_ff};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'(out_data_ff);

   // a beat in the skid register always has one ahead of it
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a beat while the output is empty");

   // the folded column angle never passes a right angle
   assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |-> ($signed(ZW'(a_rad_ff)) <= HALF_PI_Q28))
      else $error("folded angle beyond a right angle");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule
